/* src/gfwt_pkg.sv */
// Shared types and constants of the gated frequency window tracker.
package gfwt_pkg;

    localparam int CHANNELS   = 4;
    localparam int CH_IDX_W   = 2;
    localparam int VAL_W      = 32;
    localparam int TICK_W     = 8;
    localparam int FACTOR_W   = 17;
    localparam int OFFSET_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [CHANNELS-1:0] RST_CHANNEL_ENABLE = 4'd0;
    localparam logic [TICK_W-1:0]   RST_WINDOW_TICKS   = 8'd23;
    localparam logic [TICK_W-1:0]   RST_FLOOR_TICK     = 8'd2;
    localparam logic [CHANNELS-1:0] RST_PRESCALED      = 4'd14;
    localparam logic [FACTOR_W-1:0] RST_SCALE_FACTOR   = 17'd24;
    localparam logic [OFFSET_W-1:0] RST_SCALE_OFFSET   = 16'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHANNEL_ENABLE     = 3'd0,
        REG_WINDOW_TICKS       = 3'd1,
        REG_FLOOR_TICK         = 3'd2,
        REG_PRESCALED_CHANNELS = 3'd3,
        REG_SCALE_FACTOR       = 3'd4,
        REG_SCALE_OFFSET       = 3'd5
    } gfwt_reg_e;

    typedef struct packed {
        logic [CHANNELS-1:0] channel_enable;
        logic [TICK_W-1:0]   window_ticks;
        logic [TICK_W-1:0]   floor_tick;
        logic [CHANNELS-1:0] prescaled_channels;
        logic [FACTOR_W-1:0] scale_factor;
        logic [OFFSET_W-1:0] scale_offset;
    } gfwt_cfg_t;

endpackage

/* src/gfwt_if.sv */
// Gate item and result item channel interfaces.
interface gfwt_gate_if #(
    parameter int COUNT_WIDTH = 32
);
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] count_a;
    logic [COUNT_WIDTH-1:0] count_b;
    logic [COUNT_WIDTH-1:0] count_c;
    logic [COUNT_WIDTH-1:0] count_d;

    modport source (output valid, count_a, count_b, count_c, count_d, input ready);
    modport sink   (input valid, count_a, count_b, count_c, count_d, output ready);
endinterface

interface gfwt_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  chan_id;
    logic [31:0] peak_value;
    logic [31:0] floor_value;
    logic [31:0] spread;
    logic        last_of_run;

    modport source (output valid, chan_id, peak_value, floor_value, spread,
                    last_of_run, input ready);
    modport sink   (input valid, chan_id, peak_value, floor_value, spread,
                    last_of_run, output ready);
endinterface

/* src/gfwt_cfg.sv */
// Configuration register file.
module gfwt_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [gfwt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gfwt_pkg::CFG_DATA_W-1:0]      cfg_data,
    output gfwt_pkg::gfwt_cfg_t                  cfg
);
    import gfwt_pkg::*;

    gfwt_cfg_t cfg_reg;
    gfwt_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_CHANNEL_ENABLE:     cfg_next.channel_enable     = cfg_data[CHANNELS-1:0];
                REG_WINDOW_TICKS:       cfg_next.window_ticks       = cfg_data[TICK_W-1:0];
                REG_FLOOR_TICK:         cfg_next.floor_tick         = cfg_data[TICK_W-1:0];
                REG_PRESCALED_CHANNELS: cfg_next.prescaled_channels = cfg_data[CHANNELS-1:0];
                REG_SCALE_FACTOR:       cfg_next.scale_factor       = cfg_data[FACTOR_W-1:0];
                REG_SCALE_OFFSET:       cfg_next.scale_offset       = cfg_data[OFFSET_W-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_enable     <= RST_CHANNEL_ENABLE;
            cfg_reg.window_ticks       <= RST_WINDOW_TICKS;
            cfg_reg.floor_tick         <= RST_FLOOR_TICK;
            cfg_reg.prescaled_channels <= RST_PRESCALED;
            cfg_reg.scale_factor       <= RST_SCALE_FACTOR;
            cfg_reg.scale_offset       <= RST_SCALE_OFFSET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

/* src/gfwt_track.sv */
// Tick counter, peak and floor stores, and the window-end snapshot.
module gfwt_track #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gfwt_pkg::gfwt_cfg_t         cfg,
    gfwt_gate_if.sink                   gate,
    input  logic [gfwt_pkg::CHANNELS-1:0] issue_onehot,
    output logic [gfwt_pkg::CHANNELS-1:0] pend_mask,
    output logic [COUNT_WIDTH-1:0]      snap_peak  [gfwt_pkg::CHANNELS],
    output logic [COUNT_WIDTH-1:0]      snap_floor [gfwt_pkg::CHANNELS]
);
    import gfwt_pkg::*;

    logic [TICK_W-1:0]      tick_reg, tick_next, tick_inc;
    logic [COUNT_WIDTH-1:0] peak_reg  [CHANNELS];
    logic [COUNT_WIDTH-1:0] peak_next [CHANNELS];
    logic [COUNT_WIDTH-1:0] floor_reg  [CHANNELS];
    logic [COUNT_WIDTH-1:0] floor_next [CHANNELS];
    logic [COUNT_WIDTH-1:0] snap_peak_reg  [CHANNELS];
    logic [COUNT_WIDTH-1:0] snap_floor_reg [CHANNELS];
    logic [COUNT_WIDTH-1:0] cnt     [CHANNELS];
    logic [COUNT_WIDTH-1:0] upd_pk  [CHANNELS];
    logic [COUNT_WIDTH-1:0] upd_fl  [CHANNELS];
    logic [CHANNELS-1:0]    pend_reg, pend_next;
    logic                   at_end;
    logic                   accept;

    assign cnt[0] = gate.count_a;
    assign cnt[1] = gate.count_b;
    assign cnt[2] = gate.count_c;
    assign cnt[3] = gate.count_d;

    assign tick_inc   = tick_reg + TICK_W'(1);
    assign at_end     = (tick_inc >= cfg.window_ticks);
    // a window-end item waits until the previous run of results has been issued
    assign gate.ready = !(at_end && (pend_reg != '0));
    assign accept     = gate.valid && gate.ready;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            upd_pk[c] = (cfg.channel_enable[c] && (cnt[c] > peak_reg[c])) ? cnt[c] : peak_reg[c];
            upd_fl[c] = (cfg.channel_enable[c] && (tick_inc == cfg.floor_tick))
                        ? cnt[c] : floor_reg[c];
        end
    end

    always_comb
    begin
        tick_next = tick_reg;
        pend_next = pend_reg & ~issue_onehot;
        for (int c = 0; c < CHANNELS; c++)
        begin
            peak_next[c]  = peak_reg[c];
            floor_next[c] = floor_reg[c];
        end
        if (accept)
        begin
            tick_next = at_end ? '0 : tick_inc;
            for (int c = 0; c < CHANNELS; c++)
            begin
                peak_next[c]  = at_end ? '0 : upd_pk[c];
                floor_next[c] = upd_fl[c];
            end
            if (at_end)
                pend_next = cfg.channel_enable;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            pend_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                peak_reg[c]  <= '0;
                floor_reg[c] <= '0;
            end
        end
        else
        begin
            tick_reg <= tick_next;
            pend_reg <= pend_next;
            for (int c = 0; c < CHANNELS; c++)
            begin
                peak_reg[c]  <= peak_next[c];
                floor_reg[c] <= floor_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && at_end)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                snap_peak_reg[c]  <= upd_pk[c];
                snap_floor_reg[c] <= upd_fl[c];
            end
        end
    end

    assign pend_mask  = pend_reg;
    assign snap_peak  = snap_peak_reg;
    assign snap_floor = snap_floor_reg;
endmodule

/* src/gfwt_emit.sv */
// Result sequencer: picks the next pending channel, scales, and registers the result.
module gfwt_emit #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  gfwt_pkg::gfwt_cfg_t           cfg,
    input  logic [gfwt_pkg::CHANNELS-1:0] pend_mask,
    input  logic [COUNT_WIDTH-1:0]        snap_peak  [gfwt_pkg::CHANNELS],
    input  logic [COUNT_WIDTH-1:0]        snap_floor [gfwt_pkg::CHANNELS],
    output logic [gfwt_pkg::CHANNELS-1:0] issue_onehot,
    gfwt_result_if.source                 result
);
    import gfwt_pkg::*;

    logic [CH_IDX_W-1:0]       sel;
    logic                      found;
    logic [CHANNELS-1:0]       sel_onehot;
    logic                      sel_last;
    logic                      out_adv, s1_adv, issue;
    logic [VAL_W-1:0]          pk_raw, fl_raw, pk_scaled, fl_scaled;
    logic [VAL_W+FACTOR_W-1:0] pk_prod, fl_prod;

    logic                s1_valid_reg;
    logic [CH_IDX_W-1:0] s1_ch_reg;
    logic [VAL_W-1:0]    s1_pk_reg, s1_fl_reg;
    logic                s1_last_reg;

    logic                out_valid_reg;
    logic [CH_IDX_W-1:0] out_ch_reg;
    logic [VAL_W-1:0]    out_pk_reg, out_fl_reg, out_spread_reg;
    logic                out_last_reg;

    // lowest pending channel goes first
    always_comb
    begin
        sel   = '0;
        found = 1'b0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (pend_mask[i])
            begin
                sel   = CH_IDX_W'(i);
                found = 1'b1;
            end
        end
    end

    assign sel_onehot = found ? (CHANNELS'(1) << sel) : '0;
    assign sel_last   = ((pend_mask & ~sel_onehot) == '0);

    assign out_adv      = !out_valid_reg || result.ready;
    assign s1_adv       = !s1_valid_reg || out_adv;
    assign issue        = found && s1_adv;
    assign issue_onehot = issue ? sel_onehot : '0;

    assign pk_raw    = VAL_W'(snap_peak[sel]);
    assign fl_raw    = VAL_W'(snap_floor[sel]);
    assign pk_prod   = pk_raw * cfg.scale_factor;
    assign fl_prod   = fl_raw * cfg.scale_factor;
    assign pk_scaled = cfg.prescaled_channels[sel]
                       ? (pk_prod[VAL_W-1:0] + VAL_W'(cfg.scale_offset)) : pk_raw;
    assign fl_scaled = cfg.prescaled_channels[sel]
                       ? (fl_prod[VAL_W-1:0] + VAL_W'(cfg.scale_offset)) : fl_raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= found;
            if (out_adv)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_ch_reg   <= sel;
            s1_pk_reg   <= pk_scaled;
            s1_fl_reg   <= fl_scaled;
            s1_last_reg <= sel_last;
        end
        if (out_adv && s1_valid_reg)
        begin
            out_ch_reg     <= s1_ch_reg;
            out_pk_reg     <= s1_pk_reg;
            out_fl_reg     <= s1_fl_reg;
            out_spread_reg <= s1_pk_reg - s1_fl_reg;
            out_last_reg   <= s1_last_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.chan_id     = out_ch_reg;
    assign result.peak_value  = out_pk_reg;
    assign result.floor_value = out_fl_reg;
    assign result.spread      = out_spread_reg;
    assign result.last_of_run = out_last_reg;
endmodule

/* src/gated_frequency_window_tracker_core.sv */
// Top level of the gated frequency window tracker.
// Usage:
//   gate   : one item per gate tick, the edge counts of the four channels.
//   result : one item per enabled channel at each window end, in ascending
//            channel order; last_of_run marks the highest enabled channel.
//   cfg_we/cfg_index/cfg_data : register writes, taken at any edge with cfg_we.
// Timing:
//   A gate item can be taken every cycle unless a window-end item waits.
//   The peak and floor stores update at the accepting edge; a window-end
//   item also copies the updated values to a snapshot. Each result then
//   passes the scaling stage, then the output register with the spread
//   subtraction; one result per cycle while the receiver takes them.
// Stalls:
//   The output register holds while result.ready is low, and back-pressure
//   stops the sequencer. Gate items that do not end a window are still taken;
//   a window-end item waits while results of the previous window remain
//   unissued.
// Reset:
//   Tick counter, peaks, floors and pending results clear; registers take
//   their documented defaults.
module gated_frequency_window_tracker_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    gfwt_gate_if.sink                         gate,
    gfwt_result_if.source                     result,
    input  logic                              cfg_we,
    input  logic [gfwt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gfwt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gfwt_pkg::*;

    gfwt_cfg_t              cfg;
    logic [CHANNELS-1:0]    pend_mask;
    logic [CHANNELS-1:0]    issue_onehot;
    logic [COUNT_WIDTH-1:0] snap_peak  [CHANNELS];
    logic [COUNT_WIDTH-1:0] snap_floor [CHANNELS];

    // register file
    gfwt_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // tick counting, peak/floor capture, window-end snapshot
    gfwt_track #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_track (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .gate         (gate),
        .issue_onehot (issue_onehot),
        .pend_mask    (pend_mask),
        .snap_peak    (snap_peak),
        .snap_floor   (snap_floor)
    );

    // per-channel result sequencing, scaling and output register
    gfwt_emit #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pend_mask    (pend_mask),
        .snap_peak    (snap_peak),
        .snap_floor   (snap_floor),
        .issue_onehot (issue_onehot),
        .result       (result)
    );
endmodule

/* tb/sv/tb_gated_frequency_window_tracker_core.sv */
// Self-checking testbench of the gated frequency window tracker core.
module tb_gated_frequency_window_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;

    import gfwt_pkg::*;

    // Cycles with no item moving on either channel before the run is called hung.
    // Worst correct case is the longest sender gap plus the longest receiver stall
    // per result and the register write pauses; this is many times that.
    localparam int STALL_LIMIT  = 1000;
    // Pause after the last result before a register write or the end of the run.
    localparam int SETTLE_CYCLES = 8;

    typedef logic [CHANNELS-1:0][VAL_W-1:0] gate_counts_t;

    typedef struct packed {
        logic [CH_IDX_W-1:0] chan_id;
        logic [VAL_W-1:0]    peak_value;
        logic [VAL_W-1:0]    floor_value;
        logic [VAL_W-1:0]    spread;
        logic                last_of_run;
    } window_result_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  cfg_we;
    gfwt_reg_e             cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    gfwt_gate_if #(.COUNT_WIDTH(VAL_W)) gate_ch ();
    gfwt_result_if                      result_ch ();

    gated_frequency_window_tracker_core #(
        .COUNT_WIDTH (VAL_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .gate      (gate_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gate items waiting for the driver, and window results still owed by the block.
    gate_counts_t   pending_gates[$];
    window_result_t expected_results[$];

    // Shadow of the block: registers, tick counter, per-channel peak and floor.
    gfwt_cfg_t        shadow_cfg;
    logic [TICK_W-1:0] tick_no;
    logic [VAL_W-1:0]  peak_hold[CHANNELS];
    logic [VAL_W-1:0]  floor_hold[CHANNELS];

    bit idle_on;        // random gaps and stalls allowed in the current phase
    bit gate_took;      // gate item accepted at the last rising edge
    int idle_cycles;
    int errors;

    // ------------------------------------------------------------------
    // Window tracker prediction
    // ------------------------------------------------------------------
    function automatic logic [VAL_W-1:0] apply_prescale(logic [VAL_W-1:0] v);
        logic [63:0] wide;
        wide = 64'(v) * 64'(shadow_cfg.scale_factor) + 64'(shadow_cfg.scale_offset);
        return wide[VAL_W-1:0];
    endfunction

    function automatic void shadow_reg_write(gfwt_reg_e idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_CHANNEL_ENABLE:     shadow_cfg.channel_enable     = val[CHANNELS-1:0];
            REG_WINDOW_TICKS:       shadow_cfg.window_ticks       = val[TICK_W-1:0];
            REG_FLOOR_TICK:         shadow_cfg.floor_tick         = val[TICK_W-1:0];
            REG_PRESCALED_CHANNELS: shadow_cfg.prescaled_channels = val[CHANNELS-1:0];
            REG_SCALE_FACTOR:       shadow_cfg.scale_factor       = val[FACTOR_W-1:0];
            REG_SCALE_OFFSET:       shadow_cfg.scale_offset       = val[OFFSET_W-1:0];
            default: ;
        endcase
    endfunction

    // One gate tick: update peaks/floors, and at window end queue one result
    // per enabled channel in ascending order.
    function automatic void track_gate(gate_counts_t cnt);
        window_result_t     r;
        logic [CHANNELS-1:0] en;
        logic [VAL_W-1:0]   pk;
        logic [VAL_W-1:0]   fl;
        int                 last_ch;
        en      = shadow_cfg.channel_enable;
        last_ch = -1;
        tick_no = tick_no + 1'b1;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (en[c])
            begin
                if (cnt[c] > peak_hold[c])
                    peak_hold[c] = cnt[c];
                if (tick_no == shadow_cfg.floor_tick)
                    floor_hold[c] = cnt[c];
                last_ch = c;
            end
        end
        // Short or shrunk windows end on the first tick at or past the limit.
        if (tick_no >= shadow_cfg.window_ticks)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (en[c])
                begin
                    pk = peak_hold[c];
                    fl = floor_hold[c];
                    if (shadow_cfg.prescaled_channels[c])
                    begin
                        pk = apply_prescale(pk);
                        fl = apply_prescale(fl);
                    end
                    r.chan_id     = CH_IDX_W'(c);
                    r.peak_value  = pk;
                    r.floor_value = fl;
                    r.spread      = pk - fl;
                    r.last_of_run = (c == last_ch);
                    expected_results.push_back(r);
                end
            end
            // Floors survive the window, peaks do not.
            tick_no = '0;
            for (int c = 0; c < CHANNELS; c++)
                peak_hold[c] = '0;
        end
    endfunction

    function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                        logic [VAL_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: register writes, accepted gate items, accepted results
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        window_result_t want;
        gate_took = gate_ch.valid && gate_ch.ready;
        if (!rst_n)
        begin
            idle_cycles = 0;
        end
        else
        begin
            if (cfg_we)
                shadow_reg_write(cfg_index, cfg_data);
            if (gate_took)
                track_gate({gate_ch.count_d, gate_ch.count_c,
                            gate_ch.count_b, gate_ch.count_a});
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result item: expected none, %s %0d %h %h %h %b",
                             $time, "actual ch", result_ch.chan_id,
                             result_ch.peak_value, result_ch.floor_value,
                             result_ch.spread, result_ch.last_of_run);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("chan_id", VAL_W'(want.chan_id),
                                VAL_W'(result_ch.chan_id));
                    check_field("peak_value", want.peak_value, result_ch.peak_value);
                    check_field("floor_value", want.floor_value, result_ch.floor_value);
                    check_field("spread", want.spread, result_ch.spread);
                    check_field("last_of_run", VAL_W'(want.last_of_run),
                                VAL_W'(result_ch.last_of_run));
                end
            end
            if (gate_took || (result_ch.valid && result_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Gate driver: holds an item until taken, random gap bursts in between
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        int           gap_left;
        gate_counts_t nxt;
        if (rst_n)
        begin
            if (!gate_ch.valid || gate_took)
            begin
                if (gap_left > 0)
                begin
                    gate_ch.valid <= 1'b0;
                    gap_left--;
                end
                else if (pending_gates.size() != 0)
                begin
                    nxt = pending_gates.pop_front();
                    gate_ch.count_a <= nxt[0];
                    gate_ch.count_b <= nxt[1];
                    gate_ch.count_c <= nxt[2];
                    gate_ch.count_d <= nxt[3];
                    gate_ch.valid   <= 1'b1;
                    if (idle_on && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 14);
                end
                else
                begin
                    gate_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: ready with random stall bursts
    always @(negedge clk)
    begin
        int stall_left;
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(1, 14);
            end
        end
    end

    // Watchdog
    initial
    begin
        wait (idle_cycles >= STALL_LIMIT);
        $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(gfwt_reg_e idx, int unsigned val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_gate(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                             logic [VAL_W-1:0] c, logic [VAL_W-1:0] d);
        pending_gates.push_back({d, c, b, a});
    endtask

    // Sender holds off until every queued item is in and every owed result
    // is out, then lets the scaling pipeline go quiet before any write.
    task automatic settle();
        do
            @(negedge clk);
        while (pending_gates.size() != 0 || gate_ch.valid || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [VAL_W-1:0] rand_count();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return VAL_W'($urandom_range(0, 1000));
            3:       return '1 - VAL_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int random_items;
        int phase_no;
        int n_items;
        int win;
        bit late;

        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_CHANNEL_ENABLE;
        cfg_data        = '0;
        gate_ch.valid   = 1'b0;
        gate_ch.count_a = '0;
        gate_ch.count_b = '0;
        gate_ch.count_c = '0;
        gate_ch.count_d = '0;
        result_ch.ready = 1'b0;
        errors          = 0;
        idle_on         = 1'b1;

        shadow_cfg.channel_enable     = RST_CHANNEL_ENABLE;
        shadow_cfg.window_ticks       = RST_WINDOW_TICKS;
        shadow_cfg.floor_tick         = RST_FLOOR_TICK;
        shadow_cfg.prescaled_channels = RST_PRESCALED;
        shadow_cfg.scale_factor       = RST_SCALE_FACTOR;
        shadow_cfg.scale_offset       = RST_SCALE_OFFSET;
        tick_no = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            peak_hold[c]  = '0;
            floor_hold[c] = '0;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: all channels, reset prescale setup (channels 1-3 scaled),
        // count extremes; one window of three ticks.
        write_reg(REG_CHANNEL_ENABLE, 4'hF);
        write_reg(REG_WINDOW_TICKS, 3);
        send_gate('0, '0, '0, '0);
        send_gate('1, '1, '1, '1);
        send_gate(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE);
        settle();

        // Window length zero: every tick ends a window. Disabled channels 1 and 3.
        // Zero scale factor leaves only the offset.
        write_reg(REG_CHANNEL_ENABLE, 4'b0101);
        write_reg(REG_WINDOW_TICKS, 0);
        write_reg(REG_FLOOR_TICK, 1);
        write_reg(REG_PRESCALED_CHANNELS, 4'b0001);
        write_reg(REG_SCALE_FACTOR, 0);
        write_reg(REG_SCALE_OFFSET, 16'hFFFF);
        send_gate(32'h1234_5678, 32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_gate(32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0000, 32'hFFFF_FFFF);
        send_gate(32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
        settle();

        // Floor tick zero is never reached: floors carry over. Factor 65536.
        write_reg(REG_CHANNEL_ENABLE, 4'hF);
        write_reg(REG_WINDOW_TICKS, 1);
        write_reg(REG_FLOOR_TICK, 0);
        write_reg(REG_PRESCALED_CHANNELS, 4'hF);
        write_reg(REG_SCALE_FACTOR, 65536);
        write_reg(REG_SCALE_OFFSET, 0);
        send_gate(32'h0000_FFFF, 32'hFFFF_0000, 32'h0001_0001, 32'h7FFF_FFFF);
        send_gate(32'hFFFF_FFFF, 32'h0000_0002, 32'h8000_0001, 32'h0000_0000);
        settle();

        // Window ends with no channel enabled: nothing comes out.
        write_reg(REG_CHANNEL_ENABLE, 0);
        write_reg(REG_WINDOW_TICKS, 2);
        repeat (4) send_gate(rand_count(), rand_count(), rand_count(), rand_count());
        settle();

        // Window shrunk mid-window: the next tick is already past it.
        write_reg(REG_CHANNEL_ENABLE, 4'b1000);
        write_reg(REG_WINDOW_TICKS, 10);
        write_reg(REG_FLOOR_TICK, 5);
        write_reg(REG_PRESCALED_CHANNELS, 0);
        repeat (6) send_gate(rand_count(), rand_count(), rand_count(), rand_count());
        settle();
        write_reg(REG_WINDOW_TICKS, 4);
        send_gate(32'h0000_0003, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0007);
        settle();

        // Random phases: a random subset of registers per phase, so some
        // windows straddle a change. Mostly short windows to get many results.
        random_items = 0;
        phase_no     = 0;
        while (random_items < 400)
        begin
            late = (random_items >= 340);
            if (phase_no == 4)
            begin
                // Longest window, floor near its end.
                write_reg(REG_CHANNEL_ENABLE, $urandom_range(1, 15));
                write_reg(REG_WINDOW_TICKS, 255);
                write_reg(REG_FLOOR_TICK, $urandom_range(250, 255));
                n_items = 256;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0:       win = $urandom_range(0, 2);
                    1:       win = $urandom_range(13, 60);
                    default: win = $urandom_range(3, 12);
                endcase
                if ($urandom_range(0, 3) != 0)
                    write_reg(REG_CHANNEL_ENABLE, $urandom_range(0, 15));
                if ($urandom_range(0, 2) != 0)
                    write_reg(REG_WINDOW_TICKS, win);
                if ($urandom_range(0, 1) != 0)
                    write_reg(REG_FLOOR_TICK, ($urandom_range(0, 5) == 0) ?
                              $urandom_range(0, 255) : $urandom_range(0, win + 3));
                if ($urandom_range(0, 1) != 0)
                    write_reg(REG_PRESCALED_CHANNELS, $urandom_range(0, 15));
                if ($urandom_range(0, 1) != 0)
                begin
                    case ($urandom_range(0, 4))
                        0:       write_reg(REG_SCALE_FACTOR, 0);
                        1:       write_reg(REG_SCALE_FACTOR, 1);
                        2:       write_reg(REG_SCALE_FACTOR, 65536);
                        3:       write_reg(REG_SCALE_FACTOR, $urandom_range(0, 131071));
                        default: write_reg(REG_SCALE_FACTOR, $urandom_range(1, 300));
                    endcase
                end
                if ($urandom_range(0, 1) != 0)
                    write_reg(REG_SCALE_OFFSET, $urandom_range(0, 65535));
                n_items = $urandom_range(8, 40);
            end
            // Some phases run with no idling; the tail of the run has none.
            idle_on = !late && ($urandom_range(0, 4) != 0);
            repeat (n_items)
                send_gate(rand_count(), rand_count(), rand_count(), rand_count());
            random_items += n_items;
            phase_no++;
            settle();
        end

        repeat (20) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
